### rtl/brf_pkg.sv
// ----------------------------------------------------------------------------
// brf_pkg: shared types and constants for the byte ring FIFO
// Store geometry, field widths, operation codes, scan status struct.
// ----------------------------------------------------------------------------
package brf_pkg;

  localparam int ADDR_W  = 8;             // store address width
  localparam int DEPTH   = 1 << ADDR_W;   // store entries
  localparam int BYTE_W  = 8;
  localparam int MODE_W  = 3;

  localparam logic [MODE_W-1:0] MODE_PUSH  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_POP   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PEEK  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DROP  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_FLUSH = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SEEK  = 3'd6;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [BYTE_W-1:0] byte_t;

  typedef struct packed {
    logic  done;   // scan finished this cycle
    addr_t pos;    // 1-based hit position, 0 if absent
  } scan_stat_t;

endpackage

### rtl/brf_store.sv
// ----------------------------------------------------------------------------
// brf_store: byte store of the ring FIFO
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module brf_store
  import brf_pkg::*;
(
  input  logic  clk,
  input  logic  wr_en,
  input  addr_t wr_addr,
  input  byte_t wr_data,
  input  addr_t rd_addr,
  output byte_t rd_data
);

  byte_t mem [DEPTH];
  byte_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/brf_scan.sv
// ----------------------------------------------------------------------------
// brf_scan: needle search unit
// Walks offsets from the head, one read issued per cycle, and compares each
// returned byte against the needle in the cycle after its read.
// ----------------------------------------------------------------------------
module brf_scan
  import brf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  byte_t      needle,
  input  addr_t      fill,
  input  byte_t      rd_data,
  output addr_t      offset,
  output scan_stat_t stat
);

  logic  busy_r, busy_nxt;
  logic  pend_v_r, pend_v_nxt;
  addr_t off_r, off_nxt;
  addr_t pend_pos_r, pend_pos_nxt;
  logic  hit, last;

  assign hit  = pend_v_r && (rd_data == needle);
  assign last = pend_v_r && (pend_pos_r == fill);

  always_comb begin
    busy_nxt     = busy_r;
    pend_v_nxt   = 1'b0;
    off_nxt      = off_r;
    pend_pos_nxt = pend_pos_r;
    stat.done    = busy_r && (hit || last);
    stat.pos     = hit ? pend_pos_r : '0;
    if (start) begin
      busy_nxt = 1'b1;
      off_nxt  = '0;
    end else if (busy_r) begin
      if (stat.done) begin
        busy_nxt = 1'b0;
      end else if (off_r < fill) begin
        off_nxt      = off_r + addr_t'(1);
        pend_v_nxt   = 1'b1;
        pend_pos_nxt = off_r + addr_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      pend_v_r <= pend_v_nxt;
    end
    off_r      <= off_nxt;
    pend_pos_r <= pend_pos_nxt;
  end

  assign offset = off_r;

endmodule

### rtl/byte_ring_fifo_with_seek.sv
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_seek: circular byte FIFO with read, peek and seek
// Each beat is latched in S_IDLE and decoded in S_EXEC; pop, read and peek
// that return a stored byte then take the registered store data in S_RDDONE;
// a seek over a nonempty queue waits in S_SEEK until the scan hits or ends;
// a flush zeroes one store entry per cycle in S_CLEAR.
// Throughput: one beat in flight; the next is taken in S_IDLE once the result
// slot drains. Reset: a clearing pass zeroes the store; in_tready stays low.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_seek
  import brf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] value, [15:8] index
  input  logic [2:0]  in_tuser,   // [2:0] mode
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] data_out, [15:8] seek_position, [23:16] fill_level
  output logic        out_tuser   // [0] dropped
);

  typedef enum logic [2:0] {
    S_CLEAR,   // zero sweep over the store (reset or flush)
    S_IDLE,    // waiting for a beat
    S_EXEC,    // decode the latched beat
    S_RDDONE,  // store read data available
    S_SEEK     // scan unit walking the queue
  } state_t;

  state_t      state_r, state_nxt;
  addr_t       head_r, head_nxt;
  addr_t       tail_r, tail_nxt;
  addr_t       clr_r, clr_nxt;
  logic        flush_r, flush_nxt;
  logic [MODE_W-1:0] mode_r;
  byte_t       value_r;
  addr_t       index_r;

  // result register
  logic        out_valid_r;
  logic [23:0] out_data_r;
  logic        out_drop_r;

  // store ports
  logic        wr_en;
  addr_t       wr_addr;
  byte_t       wr_data;
  addr_t       rd_addr;
  byte_t       rd_data;

  // scan unit
  logic        scan_start;
  addr_t       scan_off;
  scan_stat_t  scan_stat;

  // result being formed this cycle
  logic        emit;
  byte_t       res_data;
  addr_t       res_pos;
  logic        res_drop;
  addr_t       fill;
  addr_t       fill_nxt;
  logic        accept;

  // ring arithmetic relies on DEPTH being a power of two
  assign fill     = tail_r - head_r;
  assign fill_nxt = tail_nxt - head_nxt;

  // new beat may enter in S_IDLE when the result slot is free or being drained
  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    clr_nxt    = clr_r;
    flush_nxt  = flush_r;
    wr_en      = 1'b0;
    wr_addr    = tail_r;
    wr_data    = '0;
    rd_addr    = head_r;
    scan_start = 1'b0;
    emit       = 1'b0;
    res_data   = '0;
    res_pos    = '0;
    res_drop   = 1'b0;

    case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        clr_nxt = clr_r + addr_t'(1);
        if (clr_r == addr_t'(DEPTH - 1)) begin
          emit      = flush_r;   // reset sweep reports nothing
          flush_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt = S_IDLE;
        case (mode_r)
          MODE_PUSH: begin
            emit = 1'b1;
            if (fill != addr_t'(DEPTH - 1)) begin
              wr_en    = 1'b1;
              wr_data  = value_r;
              tail_nxt = tail_r + addr_t'(1);
            end else begin
              res_drop = 1'b1;
            end
          end
          MODE_POP: begin
            if (fill != '0) begin
              state_nxt = S_RDDONE;
            end else begin
              emit = 1'b1;
            end
          end
          MODE_READ: begin
            // an 8-bit index always lands inside the store
            rd_addr   = index_r;
            state_nxt = S_RDDONE;
          end
          MODE_PEEK: begin
            if (index_r < fill) begin
              rd_addr   = head_r + index_r;
              state_nxt = S_RDDONE;
            end else begin
              emit = 1'b1;
            end
          end
          MODE_DROP: begin
            emit = 1'b1;
            if (fill != '0) begin
              tail_nxt = tail_r - addr_t'(1);
              wr_en    = 1'b1;
              wr_addr  = tail_r - addr_t'(1);
            end
          end
          MODE_FLUSH: begin
            head_nxt  = '0;
            tail_nxt  = '0;
            clr_nxt   = '0;
            flush_nxt = 1'b1;
            state_nxt = S_CLEAR;
          end
          MODE_SEEK: begin
            if (fill != '0) begin
              scan_start = 1'b1;
              state_nxt  = S_SEEK;
            end else begin
              emit = 1'b1;
            end
          end
          default: begin
            emit = 1'b1;   // unused code: report level only
          end
        endcase
      end

      S_RDDONE: begin
        emit      = 1'b1;
        res_data  = rd_data;
        state_nxt = S_IDLE;
        if (mode_r == MODE_POP) begin
          // popped slot goes back to zero
          wr_en    = 1'b1;
          wr_addr  = head_r;
          head_nxt = head_r + addr_t'(1);
        end
      end

      S_SEEK: begin
        rd_addr = head_r + scan_off;
        if (scan_stat.done) begin
          emit      = 1'b1;
          res_pos   = scan_stat.pos;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      head_r      <= '0;
      tail_r      <= '0;
      clr_r       <= '0;
      flush_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      clr_r   <= clr_nxt;
      flush_r <= flush_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (accept) begin
      mode_r  <= in_tuser;
      value_r <= in_tdata[7:0];
      index_r <= in_tdata[15:8];
    end
    if (emit) begin
      out_data_r <= {fill_nxt, res_pos, res_data};
      out_drop_r <= res_drop;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_drop_r;

  brf_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  brf_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (scan_start),
    .needle  (value_r),
    .fill    (fill),
    .rd_data (rd_data),
    .offset  (scan_off),
    .stat    (scan_stat)
  );

endmodule

### verif/byte_ring_fifo_with_seek_tb.sv
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_seek_tb: self-checking bench for the byte ring FIFO
// Drives mode/value/index beats into the FIFO and predicts each result beat
// with a shadow copy of the store and pointers. Directed corner beats come
// first, then random runs that fill, drain and mix the queue. Both sides
// idle at random, with one long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_seek_tb;
  import brf_pkg::*;

  localparam logic [MODE_W-1:0] MODE_NOP = 3'd7;  // unused code, no operation
  localparam int IDLE_PCT      = 16;
  localparam int RANDOM_BEATS  = 1450;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_AT       = 300;             // result count that starts the hold-off

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    byte_t             value;
    addr_t             index;
  } fifo_beat_t;

  typedef struct packed {
    byte_t data_out;
    byte_t seek_position;
    byte_t fill_level;
    logic  dropped;
  } fifo_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [7:0] value, [15:8] index
  logic [2:0]  in_tuser = '0;   // [2:0] mode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // [7:0] data_out, [15:8] seek_position, [23:16] fill_level
  logic        out_tuser;       // [0] dropped

  // shadow FIFO state
  byte_t shadow_store [DEPTH];
  addr_t head_ptr;
  addr_t tail_ptr;

  fifo_beat_t   pending_beats [$];
  fifo_result_t expected_results [$];
  fifo_beat_t   beat_on_bus;
  fifo_result_t want;
  int           beats_sent = 0;
  int           results_seen = 0;
  int           hold_left = 0;
  logic         hold_done = 1'b0;
  int           errors = 0;

  byte_ring_fifo_with_seek i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #10 clk = ~clk;

  // Apply one accepted beat to the shadow FIFO and return its result.
  // DEPTH is a power of two equal to the pointer range, so pointer math
  // wraps by itself at ADDR_W bits.
  function automatic fifo_result_t apply_beat(fifo_beat_t b);
    fifo_result_t res;
    addr_t        level;
    addr_t        p;
    logic         found;
    res   = '0;
    level = addr_t'(tail_ptr - head_ptr);
    case (b.mode)
      MODE_PUSH: begin
        if (int'(level) < DEPTH - 1) begin
          shadow_store[tail_ptr] = b.value;
          tail_ptr = tail_ptr + 1'b1;
        end else begin
          res.dropped = 1'b1;      // full: byte discarded
        end
      end
      MODE_POP: begin
        if (level != 0) begin
          res.data_out = shadow_store[head_ptr];
          shadow_store[head_ptr] = '0;
          head_ptr = head_ptr + 1'b1;
        end
      end
      MODE_READ: begin
        res.data_out = shadow_store[b.index];   // 8-bit index never exceeds DEPTH-1
      end
      MODE_PEEK: begin
        if (b.index < level) res.data_out = shadow_store[addr_t'(head_ptr + b.index)];
      end
      MODE_DROP: begin
        if (level != 0) begin
          tail_ptr = tail_ptr - 1'b1;
          shadow_store[tail_ptr] = '0;
        end
      end
      MODE_FLUSH: begin
        for (int i = 0; i < DEPTH; i++) shadow_store[i] = '0;
        head_ptr = '0;
        tail_ptr = '0;
      end
      MODE_SEEK: begin
        p     = head_ptr;
        found = 1'b0;
        for (int n = 1; n <= int'(level); n++) begin
          if (!found && shadow_store[p] == b.value) begin
            res.seek_position = byte_t'(n);
            found = 1'b1;
          end
          p = p + 1'b1;
        end
      end
      default: ;                   // unused code: only the level is reported
    endcase
    res.fill_level = byte_t'(tail_ptr - head_ptr);
    return res;
  endfunction

  task automatic queue_beat(logic [MODE_W-1:0] mode, byte_t value, addr_t index);
    fifo_beat_t b;
    b.mode  = mode;
    b.value = value;
    b.index = index;
    pending_beats.push_back(b);
  endtask

  // Random beat with given push/pop/flush percentages; the remainder is
  // spread over read, peek, drop, seek and the unused code. Values lean on a
  // small alphabet half the time so that seeks hit often.
  function automatic fifo_beat_t random_beat(int push_pct, int pop_pct, int flush_pct);
    fifo_beat_t b;
    int         r;
    b.value = ($urandom_range(1) == 1) ? byte_t'($urandom_range(15)) : byte_t'($urandom);
    b.index = ($urandom_range(1) == 1) ? addr_t'($urandom_range(7)) : addr_t'($urandom);
    r = $urandom_range(99);
    if (r < push_pct) begin
      b.mode = MODE_PUSH;
    end else if (r < push_pct + pop_pct) begin
      b.mode = MODE_POP;
    end else if (r < push_pct + pop_pct + flush_pct) begin
      b.mode = MODE_FLUSH;
    end else begin
      r = $urandom_range(99);
      if (r < 20)      b.mode = MODE_READ;
      else if (r < 45) b.mode = MODE_PEEK;
      else if (r < 62) b.mode = MODE_DROP;
      else if (r < 96) b.mode = MODE_SEEK;
      else             b.mode = MODE_NOP;
    end
    return b;
  endfunction

  // Driver: hold the beat until accepted, then predict it and move on.
  // No idling while beats 700..899 are sent.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        expected_results.push_back(apply_beat(beat_on_bus));
        beats_sent <= beats_sent + 1;
      end
      if (pending_beats.size() != 0 &&
          ((beats_sent >= 700 && beats_sent < 900) || $urandom_range(99) >= IDLE_PCT)) begin
        beat_on_bus = pending_beats.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {beat_on_bus.index, beat_on_bus.value};
        in_tuser  <= beat_on_bus.mode;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver ready: one long hold-off, a calm window, random stalls otherwise.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      hold_done  <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= (results_seen >= 1000 && results_seen < 1200) ||
                    ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Monitor: every result beat against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected: tdata %h tuser %b", out_tdata, out_tuser);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_tdata[7:0] !== want.data_out) begin
          $error("data_out: expected %h, got %h", want.data_out, out_tdata[7:0]);
          errors++;
        end
        if (out_tdata[15:8] !== want.seek_position) begin
          $error("seek_position: expected %0d, got %0d", want.seek_position, out_tdata[15:8]);
          errors++;
        end
        if (out_tdata[23:16] !== want.fill_level) begin
          $error("fill_level: expected %0d, got %0d", want.fill_level, out_tdata[23:16]);
          errors++;
        end
        if (out_tuser !== want.dropped) begin
          $error("dropped: expected %b, got %b", want.dropped, out_tuser);
          errors++;
        end
      end
    end
  end

  initial begin
    int run_len;
    int kind;
    int total;

    for (int i = 0; i < DEPTH; i++) shadow_store[i] = '0;
    head_ptr = '0;
    tail_ptr = '0;

    // directed: empty-queue corners, field extremes, every mode
    queue_beat(MODE_POP,   8'h00, 8'h00);   // pop when empty
    queue_beat(MODE_DROP,  8'hFF, 8'hFF);   // drop newest when empty
    queue_beat(MODE_PEEK,  8'h00, 8'h00);   // peek with nothing held
    queue_beat(MODE_SEEK,  8'h00, 8'h00);   // seek in empty queue
    queue_beat(MODE_READ,  8'h00, 8'h00);
    queue_beat(MODE_READ,  8'hFF, 8'hFF);
    queue_beat(MODE_NOP,   8'hFF, 8'hFF);   // unused code
    queue_beat(MODE_PUSH,  8'h00, 8'hFF);
    queue_beat(MODE_PUSH,  8'hFF, 8'h00);
    queue_beat(MODE_PUSH,  8'h5A, 8'h00);
    queue_beat(MODE_PUSH,  8'hA5, 8'h00);
    queue_beat(MODE_PEEK,  8'h00, 8'h00);
    queue_beat(MODE_PEEK,  8'h00, 8'h03);
    queue_beat(MODE_PEEK,  8'h00, 8'h04);   // first offset past the data
    queue_beat(MODE_PEEK,  8'h00, 8'hFF);
    queue_beat(MODE_SEEK,  8'hA5, 8'h00);   // hit at the newest byte
    queue_beat(MODE_SEEK,  8'h00, 8'h00);   // hit at the head
    queue_beat(MODE_SEEK,  8'h33, 8'h00);   // absent needle
    queue_beat(MODE_READ,  8'h00, 8'h01);
    queue_beat(MODE_DROP,  8'h00, 8'h00);
    queue_beat(MODE_POP,   8'h00, 8'h00);
    queue_beat(MODE_POP,   8'h00, 8'h00);
    queue_beat(MODE_FLUSH, 8'hFF, 8'hFF);
    queue_beat(MODE_POP,   8'h00, 8'h00);
    queue_beat(MODE_READ,  8'h00, 8'h02);   // cleared by the flush

    // random runs: the first one fills past full, later ones drain or mix
    total = 0;
    kind  = 0;
    while (total < RANDOM_BEATS) begin
      if (kind == 0) begin
        run_len = $urandom_range(330, 380);
      end else if (kind == 1) begin
        run_len = $urandom_range(40, 160);
      end else begin
        run_len = $urandom_range(30, 90);
      end
      if (run_len > RANDOM_BEATS - total) run_len = RANDOM_BEATS - total;
      if (kind == 0) begin
        for (int i = 0; i < run_len; i++) pending_beats.push_back(random_beat(88, 3, 0));
      end else if (kind == 1) begin
        for (int i = 0; i < run_len; i++) pending_beats.push_back(random_beat(10, 55, 0));
      end else begin
        for (int i = 0; i < run_len; i++) pending_beats.push_back(random_beat(40, 30, 1));
      end
      total += run_len;
      kind = $urandom_range(3);
      if (kind == 3) kind = 2;
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_beats.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
    // flush is the slowest step; give stray beats time to show
    repeat (DEPTH + 8) @(posedge clk);

    if (errors == 0) begin
      $display("byte_ring_fifo_with_seek_tb passed");
    end else begin
      $display("byte_ring_fifo_with_seek_tb failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40000000;
    $display("byte_ring_fifo_with_seek_tb failed");
    $finish;
  end

endmodule
